// File: rtl/qds_pkg.sv
// Package with the shared constants and types of the quadrature decoder with speed estimate.
`timescale 1ns / 1ps
`default_nettype none
package qds_pkg;

    localparam int unsigned DvdWidth = 74;
    localparam int unsigned DvsWidth = 32;
    localparam int unsigned CntWidth = $clog2(DvdWidth + 1);

    localparam logic [23:0] EdgeWrapLimit   = 24'd10000000;
    localparam logic signed [31:0] CountClearLimit = 32'sd2000000;
    localparam logic [3:0]  PatOneNine      = 4'b1001;
    localparam logic [3:0]  PatZeroThree    = 4'b0011;
    localparam logic [16:0] WeightOne       = 17'd65536;
    localparam logic signed [31:0] CountMax = 32'sh7FFFFFFF;
    localparam logic signed [31:0] CountMin = 32'sh80000000;
    localparam logic signed [63:0] SpeedMax = 64'sh7FFFFFFFFFFFFFFF;
    localparam logic signed [63:0] SpeedMin = 64'sh8000000000000000;

    localparam logic [31:0] DistPerCountReset = 32'd655;
    localparam logic [31:0] DeadbandReset     = 32'd655;
    localparam logic [16:0] WeightReset       = 17'd32768;

    typedef enum logic [1:0] {
        REG_DIST_PER_COUNT = 2'd0,
        REG_STOP_DEADBAND  = 2'd1,
        REG_FILTER_WEIGHT  = 2'd2,
        REG_UNUSED         = 2'd3
    } reg_index_t;

endpackage
`default_nettype wire

// File: rtl/qds_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module qds_div
    import qds_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DvdWidth-1:0] dividend,
    input  wire logic [DvsWidth-1:0] divisor,
    output logic                     busy,
    output logic                     done,
    output logic [DvdWidth-1:0]      quotient
);

    logic                busy_reg;
    logic                done_reg;
    logic [CntWidth-1:0] cnt_reg;
    logic [DvdWidth-1:0] dvd_reg;
    logic [DvsWidth-1:0] rem_reg;

    logic [DvsWidth:0]   trial;
    logic [DvsWidth:0]   trial_sub;
    logic                fits;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[DvdWidth-1]};
        trial_sub = trial - {1'b0, divisor};
        fits      = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CntWidth'(DvdWidth - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Quotient bits shift into the bottom of the dividend register as it empties.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DvdWidth-2:0], fits};
            rem_reg <= fits ? trial_sub[DvsWidth-1:0] : trial[DvsWidth-1:0];
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule
`default_nettype wire

// File: rtl/quadrature_decoder_with_speed.sv
// Top level of the quadrature decoder with speed estimate.
//
// Input items arrive on in_valid/in_ready with func, level_a, level_b and time_ms.
// An edge item (func 0) updates the channel histories and the signed count and
// its result is offered on the output in the cycle after acceptance.
// A speed item (func 1) runs through a small sequencer around one shared
// 33 by 33 multiplier and a one-bit-per-cycle divider; the divider is used
// only when the distance change exceeds the deadband and the time divisor
// is non-zero. The block takes no item while a speed item works.
// Each item gives one result on out_valid/out_ready. The result register holds
// while the receiver stalls; an edge item is taken only when that register is
// free or being emptied, and a speed item waits at its end for the same.
// Configuration sits on an APB-style port: distance_per_count at 0x0,
// stop_deadband at 0x4, filter_weight at 0x8; pready is always high.
// Reset clears all counts, the stored edge and query timestamps and the filter,
// and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module quadrature_decoder_with_speed
    import qds_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               func,
    input  wire logic               level_a,
    input  wire logic               level_b,
    input  wire logic [31:0]        time_ms,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      position,
    output logic                    moved_left,
    output logic                    moved_right,
    output logic signed [63:0]      speed,
    output logic                    zero_interval
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_DIST, S_DIFF, S_MAG, S_CHECK, S_SCALE, S_DIV, S_RAW, S_IIR, S_FIN
    } state_t;

    state_t             state_reg;
    logic [31:0]        dpc_reg;
    logic [31:0]        deadband_reg;
    logic [16:0]        weight_reg;
    logic [3:0]         hist_a_reg;
    logic [3:0]         hist_b_reg;
    logic signed [31:0] count_reg;
    logic [23:0]        edge_events_reg;
    logic               left_reg;
    logic               right_reg;
    logic [31:0]        last_edge_reg;
    logic [31:0]        prior_edge_reg;
    logic [31:0]        last_query_reg;
    logic signed [63:0] prev_dist_reg;
    logic signed [63:0] filt_reg;

    logic [31:0]        t_reg;
    logic signed [63:0] dist_reg;
    logic signed [63:0] diff_reg;
    logic [63:0]        mag_reg;
    logic               neg_reg;
    logic [31:0]        dvs_reg;
    logic [DvdWidth-1:0] scaled_reg;
    logic signed [63:0] raw_reg;
    logic               zero_reg;
    logic [2:0]         step_reg;
    logic signed [65:0] prod_reg;
    logic               prod_hi_reg;
    logic signed [81:0] acc_reg;

    logic               out_valid_reg;
    logic signed [31:0] position_reg;
    logic               left_out_reg;
    logic               right_out_reg;
    logic signed [63:0] speed_reg;
    logic               zero_out_reg;

    logic               in_accept;
    logic               out_free;
    logic               out_load;
    logic [3:0]         hist_a_next;
    logic [3:0]         hist_b_next;
    logic signed [31:0] count_next;
    logic               step_up;
    logic               step_down;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [64:0] sub_wide;
    logic [31:0]        divisor_next;
    logic [16:0]        w_eff;
    logic [16:0]        w_old;
    logic signed [81:0] prod_ext;
    logic [63:0]        q_low;
    logic               q_big;
    logic               div_start;
    logic               div_busy;
    logic               div_done;
    logic [DvdWidth-1:0] quotient;
    reg_index_t         wr_index;

    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[3:2]);
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign in_accept = in_valid && in_ready;
    assign out_load = (in_accept && !func) || ((state_reg == S_FIN) && out_free);

    always_comb
    begin
        case (wr_index)
            REG_DIST_PER_COUNT: prdata = dpc_reg;
            REG_STOP_DEADBAND:  prdata = deadband_reg;
            REG_FILTER_WEIGHT:  prdata = {15'd0, weight_reg};
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        hist_a_next = {hist_a_reg[2:0], level_a};
        hist_b_next = {hist_b_reg[2:0], level_b};
        step_up     = (hist_a_next == PatOneNine) && (hist_b_next == PatZeroThree);
        step_down   = (hist_a_next == PatZeroThree) && (hist_b_next == PatOneNine);
        count_next  = count_reg;
        if (step_up)
        begin
            count_next = count_reg + 32'sd1;
            if (count_next == CountMax)
            begin
                count_next = '0;
            end
        end
        else if (step_down)
        begin
            count_next = count_reg - 32'sd1;
            if (count_next == CountMin)
            begin
                count_next = '0;
            end
        end
    end

    always_comb
    begin
        w_eff = (weight_reg > WeightOne) ? WeightOne : weight_reg;
        w_old = WeightOne - w_eff;
        sub_wide = {dist_reg[63], dist_reg} - {prev_dist_reg[63], prev_dist_reg};
        divisor_next = (last_edge_reg - prior_edge_reg) + (t_reg - last_query_reg);
        q_low = quotient[63:0];
        q_big = |quotient[DvdWidth-1:63];
        prod_ext = 82'(prod_reg);
        if (prod_hi_reg)
        begin
            prod_ext = prod_ext <<< 32;
        end
    end

    // Operand selection for the one shared multiplier.
    always_comb
    begin
        mul_a = {count_reg[31], count_reg};
        mul_b = {1'b0, dpc_reg};
        if (state_reg == S_IIR)
        begin
            case (step_reg[1:0])
                2'd0:
                begin
                    mul_a = {1'b0, raw_reg[31:0]};
                    mul_b = {16'd0, w_eff};
                end
                2'd1:
                begin
                    mul_a = {raw_reg[63], raw_reg[63:32]};
                    mul_b = {16'd0, w_eff};
                end
                2'd2:
                begin
                    mul_a = {1'b0, filt_reg[31:0]};
                    mul_b = {16'd0, w_old};
                end
                default:
                begin
                    mul_a = {filt_reg[63], filt_reg[63:32]};
                    mul_b = {16'd0, w_old};
                end
            endcase
        end
        mul_p = mul_a * mul_b;
    end

    assign div_start = (state_reg == S_SCALE);

    qds_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scaled_reg - {7'd0, mag_reg, 3'b000}),
        .divisor  (dvs_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            dpc_reg         <= DistPerCountReset;
            deadband_reg    <= DeadbandReset;
            weight_reg      <= WeightReset;
            hist_a_reg      <= '0;
            hist_b_reg      <= '0;
            count_reg       <= '0;
            edge_events_reg <= '0;
            left_reg        <= 1'b0;
            right_reg       <= 1'b0;
            last_edge_reg   <= '0;
            prior_edge_reg  <= '0;
            last_query_reg  <= '0;
            prev_dist_reg   <= '0;
            filt_reg        <= '0;
            out_valid_reg   <= 1'b0;
            step_reg        <= '0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                case (wr_index)
                    REG_DIST_PER_COUNT: dpc_reg <= pwdata;
                    REG_STOP_DEADBAND:  deadband_reg <= pwdata;
                    REG_FILTER_WEIGHT:  weight_reg <= pwdata[16:0];
                    default:            ;
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        t_reg <= time_ms;
                        if (!func)
                        begin
                            edge_events_reg <= (edge_events_reg > EdgeWrapLimit) ? '0
                                               : edge_events_reg + 24'd1;
                            hist_a_reg     <= hist_a_next;
                            hist_b_reg     <= hist_b_next;
                            count_reg      <= count_next;
                            if (step_up)
                            begin
                                left_reg  <= 1'b1;
                                right_reg <= 1'b0;
                            end
                            else if (step_down)
                            begin
                                left_reg  <= 1'b0;
                                right_reg <= 1'b1;
                            end
                            prior_edge_reg <= last_edge_reg;
                            last_edge_reg  <= time_ms;
                            position_reg   <= count_next;
                            left_out_reg   <= step_up ? 1'b1 : (step_down ? 1'b0 : left_reg);
                            right_out_reg  <= step_down ? 1'b1 : (step_up ? 1'b0 : right_reg);
                            speed_reg      <= filt_reg;
                            zero_out_reg   <= 1'b0;
                        end
                        else
                        begin
                            if (count_reg > CountClearLimit)
                            begin
                                count_reg <= '0;
                            end
                            zero_reg  <= 1'b0;
                            raw_reg   <= '0;
                            state_reg <= S_MUL_DIST;
                        end
                    end
                end
                S_MUL_DIST:
                begin
                    dist_reg  <= mul_p[63:0];
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    if (sub_wide[64] != sub_wide[63])
                    begin
                        diff_reg <= sub_wide[64] ? SpeedMin : SpeedMax;
                    end
                    else
                    begin
                        diff_reg <= sub_wide[63:0];
                    end
                    state_reg <= S_MAG;
                end
                S_MAG:
                begin
                    mag_reg   <= diff_reg[63] ? (~diff_reg + 64'd1) : diff_reg;
                    neg_reg   <= diff_reg[63];
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    step_reg <= '0;
                    acc_reg  <= '0;
                    if (mag_reg <= {32'd0, deadband_reg})
                    begin
                        state_reg <= S_IIR;
                    end
                    else if (divisor_next == '0)
                    begin
                        zero_reg  <= 1'b1;
                        state_reg <= S_IIR;
                    end
                    else
                    begin
                        // Times 1000 as 1024 - 16 - 8; the last term is taken off at start.
                        dvs_reg    <= divisor_next;
                        scaled_reg <= {mag_reg, 10'd0} - {6'd0, mag_reg, 4'd0};
                        state_reg  <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_RAW;
                    end
                end
                S_RAW:
                begin
                    if (neg_reg)
                    begin
                        raw_reg <= (q_big || q_low[63]) ? SpeedMin : -q_low;
                    end
                    else
                    begin
                        raw_reg <= (q_big || q_low[63]) ? SpeedMax : q_low;
                    end
                    step_reg  <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_IIR;
                end
                S_IIR:
                begin
                    // Multiply and accumulate run one step apart.
                    if (step_reg != 3'd4)
                    begin
                        prod_reg    <= mul_p;
                        prod_hi_reg <= step_reg[0];
                        step_reg    <= step_reg + 3'd1;
                    end
                    else
                    begin
                        state_reg <= S_FIN;
                    end
                    if (step_reg != 3'd0)
                    begin
                        acc_reg <= acc_reg + prod_ext;
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        filt_reg       <= acc_reg[79:16];
                        prev_dist_reg  <= dist_reg;
                        last_query_reg <= t_reg;
                        position_reg   <= count_reg;
                        left_out_reg   <= left_reg;
                        right_out_reg  <= right_reg;
                        speed_reg      <= acc_reg[79:16];
                        zero_out_reg   <= zero_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign position      = position_reg;
    assign moved_left    = left_out_reg;
    assign moved_right   = right_out_reg;
    assign speed         = speed_reg;
    assign zero_interval = zero_out_reg;

    a_edge_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !func) |=> out_valid_reg)
        else $error("edge item did not produce a result in the next cycle");

    a_speed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && func) |=> (state_reg == S_MUL_DIST) && !in_ready)
        else $error("speed item did not start the sequencer");

    a_div_owned: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == S_DIV))
        else $error("divider running outside the divide step");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && zero_reg) |-> (raw_reg == '0))
        else $error("zero divisor left a non-zero raw speed");

endmodule
`default_nettype wire
